// ===== src/imrot_pkg.sv =====
package imrot_pkg;

    // Field widths
    localparam int COORD_W        = 12;
    localparam int PIX_W          = 8;
    localparam int ANGLE_W        = 9;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_INDEX_W    = 1;

    // Fixed-point trig format: signed, TRIG_FRAC_BITS fraction bits
    localparam int TRIG_FRAC_BITS = 14;
    localparam int MAG_W          = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W         = MAG_W + 1;

    // Datapath widths
    localparam int OFS_W          = COORD_W + 1;
    localparam int PROD_W         = OFS_W + TRIG_W;
    localparam int SUM_W          = PROD_W + 2;
    localparam int Q_W            = SUM_W - TRIG_FRAC_BITS;

    // Angle folding
    localparam int ANGLE_FULL     = 360;
    localparam int ANGLE_QUAD     = 90;
    localparam int TRIG_DEPTH     = ANGLE_QUAD;
    localparam int TRIG_IDX_W     = $clog2(TRIG_DEPTH);
    localparam int TRIG_ENTRY_W   = 2 * MAG_W;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE  = 1'b1;

    localparam logic [ANGLE_W-1:0] ANGLE_RESET = '0;
    localparam logic [COORD_W-1:0] SIZE_RESET  = COORD_W'(1);

    // Q30 constants for table generation
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int          RND_SH  = 30 - TRIG_FRAC_BITS;

    typedef logic [TRIG_DEPTH-1:0][TRIG_ENTRY_W-1:0] trig_rom_t;

    // Eleven-term Taylor series on magnitudes, Q30, truncating each step;
    // term n is divided by k*(k+1), k starting at 2 (sine) or 1 (cosine)
    function automatic logic [63:0] series_q30(logic [63:0] theta, logic is_sine);
        logic [63:0] t2;
        logic [63:0] term;
        longint      sum;
        t2   = (theta * theta) >> 30;
        term = is_sine ? theta : ONE_Q30;
        sum  = longint'(term);
        if (is_sine)
        begin
            term = ((term * t2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd272;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd342;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd420;
            sum  = sum + longint'(term);
        end
        else
        begin
            term = ((term * t2) >> 30) / 64'd2;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd12;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd30;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd56;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd90;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd132;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd182;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd240;
            sum  = sum + longint'(term);
            term = ((term * t2) >> 30) / 64'd306;
            sum  = sum - longint'(term);
            term = ((term * t2) >> 30) / 64'd380;
            sum  = sum + longint'(term);
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    // Round a Q30 magnitude half up to TRIG_FRAC_BITS
    function automatic logic [MAG_W-1:0] q30_to_mag(logic [63:0] m);
        logic [63:0] r;
        r = m;
        if (RND_SH > 0)
            r = (m + (64'd1 << (RND_SH - 1))) >> RND_SH;
        return r[MAG_W-1:0];
    endfunction

    // Sine/cosine magnitudes for 0..89 degrees, {sin, cos}
    function automatic trig_rom_t build_trig_rom();
        trig_rom_t   rom;
        logic [63:0] a;
        logic [63:0] theta;
        logic [63:0] sa;
        logic [63:0] ca;
        for (int r = 0; r < TRIG_DEPTH; r++)
        begin
            a     = (r <= 45) ? 64'(r) : 64'(ANGLE_QUAD - r);
            theta = (a * PI_Q30) / 64'd180;
            sa    = series_q30(theta, 1'b1);
            ca    = series_q30(theta, 1'b0);
            if (r <= 45)
                rom[r] = {q30_to_mag(sa), q30_to_mag(ca)};
            else
                rom[r] = {q30_to_mag(ca), q30_to_mag(sa)};
        end
        return rom;
    endfunction

    localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

// ===== src/imrot_if.sv =====
// Source pixel channel
interface imrot_src_if
    import imrot_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] src_row;
    logic [COORD_W-1:0] src_col;
    logic [PIX_W-1:0]   pixel_value;

    modport source (output valid, output src_row, output src_col, output pixel_value,
                    input ready);
    modport sink   (input valid, input src_row, input src_col, input pixel_value,
                    output ready);
endinterface

// Rotated pixel channel
interface imrot_dst_if
    import imrot_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] dst_row;
    logic [COORD_W-1:0] dst_col;
    logic [PIX_W-1:0]   dst_value;

    modport source (output valid, output dst_row, output dst_col, output dst_value,
                    input ready);
    modport sink   (input valid, input dst_row, input dst_col, input dst_value,
                    output ready);
endinterface

// ===== src/image_rotate_forward_map.sv =====
// Forward-mapping nearest-neighbor rotation of a grey image, one source pixel per
// cycle. Each item (row, column, value) is rotated by the configured whole-degree
// angle about (c, c), c = out_size/2, using signed Q1.14 sine/cosine from an
// internal constant table; coordinates are truncated toward zero and the pixel
// is emitted only if both land in 0..out_size-1, otherwise it is dropped. The
// pipeline is four registers deep (trig lookup, multiply, sum, round/check), and
// an item's result is valid on the output once it has passed all four of them;
// one item can be accepted every cycle; a stalled sink holds the input off once
// every stage is full. Write rotation_degrees (index 0) and out_size (index 1)
// only while no items are in flight.
module image_rotate_forward_map
    import imrot_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    imrot_src_if.sink              in_ch,
    imrot_dst_if.source            out_ch
);

    typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_t;

    // Configuration registers
    logic [ANGLE_W-1:0] angle_reg;
    logic [COORD_W-1:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANGLE_RESET;
            size_reg  <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ANGLE: angle_reg <= cfg_wdata[ANGLE_W-1:0];
                CFG_SIZE:  size_reg  <= cfg_wdata[COORD_W-1:0];
                default:   ;
            endcase
        end
    end

    // Pipeline registers
    logic                     v1_reg, v2_reg, v3_reg, ov_reg;
    logic signed [OFS_W-1:0]  x1_reg, y1_reg;
    logic signed [TRIG_W-1:0] sin1_reg, cos1_reg;
    logic [PIX_W-1:0]         pix1_reg, pix2_reg, pix3_reg, opix_reg;
    logic signed [PROD_W-1:0] xc2_reg, ys2_reg, yc2_reg, xs2_reg;
    logic signed [SUM_W-1:0]  sr3_reg, sc3_reg;
    logic [COORD_W-1:0]       orow_reg, ocol_reg;

    // Per-stage advance, chained back from the output
    logic en1, en2, en3, en4;
    assign en4 = !ov_reg || out_ch.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ch.ready = en1;

    logic [COORD_W-1:0] cen;
    assign cen = {1'b0, size_reg[COORD_W-1:1]};

    // Stage 1: offsets to center, angle fold and trig lookup
    logic [ANGLE_W-1:0]      deg;
    quad_t                   quad;
    logic [ANGLE_W-1:0]      rem;
    logic [TRIG_ENTRY_W-1:0] entry;
    logic [MAG_W-1:0]        s_mag, c_mag;
    logic signed [TRIG_W-1:0] s_pos, c_pos, sin_next, cos_next;
    logic signed [OFS_W-1:0] x_next, y_next;

    always_comb
    begin
        deg = (angle_reg >= ANGLE_W'(ANGLE_FULL)) ? angle_reg - ANGLE_W'(ANGLE_FULL)
                                                  : angle_reg;
        if (deg >= ANGLE_W'(3 * ANGLE_QUAD))
        begin
            quad = QUAD_270;
            rem  = deg - ANGLE_W'(3 * ANGLE_QUAD);
        end
        else if (deg >= ANGLE_W'(2 * ANGLE_QUAD))
        begin
            quad = QUAD_180;
            rem  = deg - ANGLE_W'(2 * ANGLE_QUAD);
        end
        else if (deg >= ANGLE_W'(ANGLE_QUAD))
        begin
            quad = QUAD_90;
            rem  = deg - ANGLE_W'(ANGLE_QUAD);
        end
        else
        begin
            quad = QUAD_0;
            rem  = deg;
        end
        entry = TRIG_ROM[rem[TRIG_IDX_W-1:0]];
        s_mag = entry[TRIG_ENTRY_W-1:MAG_W];
        c_mag = entry[MAG_W-1:0];
        s_pos = $signed({1'b0, s_mag});
        c_pos = $signed({1'b0, c_mag});
        unique case (quad)
            QUAD_0:
            begin
                sin_next = s_pos;
                cos_next = c_pos;
            end
            QUAD_90:
            begin
                sin_next = c_pos;
                cos_next = -s_pos;
            end
            QUAD_180:
            begin
                sin_next = -s_pos;
                cos_next = -c_pos;
            end
            QUAD_270:
            begin
                sin_next = -c_pos;
                cos_next = s_pos;
            end
            default:
            begin
                sin_next = s_pos;
                cos_next = c_pos;
            end
        endcase
        x_next = $signed({1'b0, in_ch.src_row}) - $signed({1'b0, cen});
        y_next = $signed({1'b0, in_ch.src_col}) - $signed({1'b0, cen});
    end

    // Stage 3 inputs: recentered sums
    logic signed [SUM_W-1:0] cen_q, sr_next, sc_next;
    always_comb
    begin
        cen_q   = $signed({{(SUM_W-COORD_W-TRIG_FRAC_BITS){1'b0}}, cen,
                           {TRIG_FRAC_BITS{1'b0}}});
        sr_next = SUM_W'(xc2_reg) - SUM_W'(ys2_reg) + cen_q;
        sc_next = SUM_W'(yc2_reg) + SUM_W'(xs2_reg) + cen_q;
    end

    // Stage 4 inputs: truncate toward zero and range check
    logic signed [Q_W-1:0] qr, qc;
    logic [Q_W-1:0]        size_ext;
    logic                  hit;
    always_comb
    begin
        qr = sr3_reg[SUM_W-1:TRIG_FRAC_BITS];
        qc = sc3_reg[SUM_W-1:TRIG_FRAC_BITS];
        if (sr3_reg[SUM_W-1] && (sr3_reg[TRIG_FRAC_BITS-1:0] != '0))
            qr = qr + Q_W'(1);
        if (sc3_reg[SUM_W-1] && (sc3_reg[TRIG_FRAC_BITS-1:0] != '0))
            qc = qc + Q_W'(1);
        size_ext = {{(Q_W-COORD_W){1'b0}}, size_reg};
        hit = !qr[Q_W-1] && !qc[Q_W-1] && (unsigned'(qr) < size_ext)
              && (unsigned'(qc) < size_ext);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_ch.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) ov_reg <= v3_reg && hit;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x1_reg   <= x_next;
            y1_reg   <= y_next;
            sin1_reg <= sin_next;
            cos1_reg <= cos_next;
            pix1_reg <= in_ch.pixel_value;
        end
        if (en2)
        begin
            xc2_reg  <= x1_reg * cos1_reg;
            ys2_reg  <= y1_reg * sin1_reg;
            yc2_reg  <= y1_reg * cos1_reg;
            xs2_reg  <= x1_reg * sin1_reg;
            pix2_reg <= pix1_reg;
        end
        if (en3)
        begin
            sr3_reg  <= sr_next;
            sc3_reg  <= sc_next;
            pix3_reg <= pix2_reg;
        end
        if (en4)
        begin
            orow_reg <= qr[COORD_W-1:0];
            ocol_reg <= qc[COORD_W-1:0];
            opix_reg <= pix3_reg;
        end
    end

    assign out_ch.valid     = ov_reg;
    assign out_ch.dst_row   = orow_reg;
    assign out_ch.dst_col   = ocol_reg;
    assign out_ch.dst_value = opix_reg;

`ifndef SYNTHESIS
    // Input is held off only when stage 1 holds an item
    a_ready_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> v1_reg)
        else $error("input stalled with empty stage 1");

    // Emitted coordinates always lie inside the output square
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (orow_reg < size_reg))
        else $error("dst_row outside output square");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (ocol_reg < size_reg))
        else $error("dst_col outside output square");

    // An item appears in stage 2 only from stage 1
    a_stage2_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v2_reg) |-> $past(v1_reg))
        else $error("stage 2 valid without stage 1 item");
`endif

endmodule
